FILE: rtl/hpg_pkg.sv
// Shared constants, types and angle tables for the hypotrochoid point generator.
`timescale 1ns / 1ps
`default_nettype none

package hpg_pkg;

  localparam int RADIUS_BITS_DEF   = 10;
  localparam int INDEX_BITS_DEF    = 16;
  localparam int FRAC_BITS_DEF     = 8;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int OUT_BITS     = 20;
  localparam int ROT_BITS     = 16;
  localparam int PHASE_BITS   = 32;
  localparam int ANG_BITS     = 30;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [29:0] GAIN_FIX    = 30'd652032874;
  localparam logic [30:0] HALF_PI_FIX = 31'd1686629713;

  localparam int RST_OUTER  = 96;
  localparam int RST_INNER  = 36;
  localparam int RST_PEN    = 24;
  localparam int RST_POINTS = 360;
  localparam int RST_FINAL  = 360;
  localparam int RST_ROT    = 0;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_OUTER  = 3'd0,
    CFG_INNER  = 3'd1,
    CFG_PEN    = 3'd2,
    CFG_POINTS = 3'd3,
    CFG_FINAL  = 3'd4,
    CFG_ROT    = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    RU_LOAD,
    RU_GCD,
    RU_DIV,
    RU_IDLE
  } ratio_state_t;

  typedef struct packed {
    logic busy;
    logic neg;
  } ratio_status_t;

  function automatic int cfg_width(input int rb, input int ib);
    int w;
    w = ROT_BITS;
    if (rb > w) w = rb;
    if (ib > w) w = ib;
    return w;
  endfunction

  // Arctangent of 2^-k in radians with 30 fraction bits.
  function automatic logic [29:0] atan_fix(input int k);
    logic [29:0] v;
    case (k)
      0:  v = 30'd843314856;
      1:  v = 30'd497837829;
      2:  v = 30'd263043836;
      3:  v = 30'd133525158;
      4:  v = 30'd67021686;
      5:  v = 30'd33543515;
      6:  v = 30'd16775850;
      7:  v = 30'd8388437;
      8:  v = 30'd4194282;
      9:  v = 30'd2097149;
      10: v = 30'd1048575;
      11: v = 30'd524287;
      12: v = 30'd262143;
      13: v = 30'd131071;
      14: v = 30'd65535;
      15: v = 30'd32767;
      16: v = 30'd16383;
      17: v = 30'd8191;
      18: v = 30'd4095;
      19: v = 30'd2047;
      20: v = 30'd1023;
      21: v = 30'd511;
      22: v = 30'd255;
      23: v = 30'd127;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/hpg_div_cell.sv
// One restoring division step with its own remainder and shift registers.
`timescale 1ns / 1ps
`default_nettype none

module hpg_div_cell
  import hpg_pkg::*;
#(
  parameter int W  = INDEX_BITS_DEF,
  parameter int SW = PHASE_BITS
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [W-1:0]  d,
  input  wire logic [W-1:0]  rem_in,
  input  wire logic [SW-1:0] sw_in,
  output logic      [W-1:0]  rem_out,
  output logic      [SW-1:0] sw_out
);

  logic [W:0] t;
  logic [W:0] diff;
  logic       ge;

  always_comb begin
    t    = {rem_in, sw_in[SW-1]};
    ge   = (t >= {1'b0, d});
    diff = t - {1'b0, d};
  end

  // The dividend leaves at the top of the shift word while quotient bits enter below.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? diff[W-1:0] : t[W-1:0];
      sw_out  <= {sw_in[SW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hpg_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation with registered x, y and angle.
`timescale 1ns / 1ps
`default_nettype none

module hpg_cordic_cell
  import hpg_pkg::*;
#(
  parameter int XW = RADIUS_BITS_DEF + 32,
  parameter int ZW = 33,
  parameter int K  = 0
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [XW-1:0] x_in,
  input  wire logic signed [XW-1:0] y_in,
  input  wire logic signed [ZW-1:0] z_in,
  output logic      signed [XW-1:0] x_out,
  output logic      signed [XW-1:0] y_out,
  output logic      signed [ZW-1:0] z_out
);

  localparam logic signed [ZW-1:0] ANG = $signed(ZW'(atan_fix(K)));

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;

  always_comb begin
    dx = y_in >>> K;
    dy = x_in >>> K;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[ZW-1]) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - ANG;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + ANG;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hpg_ratio_unit.sv
// Sequential gcd and exact division that reduce the radii to turn count and difference.
`timescale 1ns / 1ps
`default_nettype none

module hpg_ratio_unit
  import hpg_pkg::*;
#(
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [RADIUS_BITS-1:0] outer,
  input  wire logic [RADIUS_BITS-1:0] inner,
  output logic      [RADIUS_BITS-1:0] count,
  output logic      [RADIUS_BITS-1:0] adiff,
  output ratio_status_t               status
);

  localparam int RB = RADIUS_BITS;
  localparam int CW = $clog2(RB);

  ratio_state_t st;
  ratio_state_t st_next;

  logic [RB-1:0] a;
  logic [RB-1:0] b;
  logic [RB-1:0] q0;
  logic [RB-1:0] q1;
  logic [RB-1:0] rem0;
  logic [RB-1:0] rem1;
  logic [CW-1:0] cnt;
  logic          neg;

  logic [RB-1:0] rr;
  logic [RB-1:0] big;
  logic          r_lt;
  logic [RB:0]   t0;
  logic [RB:0]   t1;
  logic          ge0;
  logic          ge1;
  logic [RB:0]   d0;
  logic [RB:0]   d1;

  always_comb begin
    rr   = (inner == '0) ? RB'(1) : inner;
    r_lt = (outer < rr);
    big  = r_lt ? (rr - outer) : (outer - rr);
    t0   = {rem0, q0[RB-1]};
    t1   = {rem1, q1[RB-1]};
    ge0  = (t0 >= {1'b0, a});
    ge1  = (t1 >= {1'b0, a});
    d0   = t0 - {1'b0, a};
    d1   = t1 - {1'b0, a};
  end

  always_comb begin
    st_next = st;
    unique case (st)
      RU_LOAD: st_next = RU_GCD;
      RU_GCD:  if (b == '0) st_next = RU_DIV;
      RU_DIV:  if (cnt == CW'(RB - 1)) st_next = RU_IDLE;
      RU_IDLE: st_next = RU_IDLE;
      default: st_next = RU_LOAD;
    endcase
    if (start) st_next = RU_LOAD;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= RU_LOAD;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    status.busy = (st != RU_IDLE);
    status.neg  = neg;
    count       = q0;
    adiff       = q1;
  end

  // Subtractive Euclid leaves the gcd in a; then both quotients are found bit by bit.
  always_ff @(posedge clk) begin
    unique case (st)
      RU_LOAD: begin
        a   <= outer;
        b   <= rr;
        q0  <= rr;
        q1  <= big;
        neg <= r_lt;
      end
      RU_GCD: begin
        if (b != '0) begin
          if (a >= b) begin
            a <= a - b;
          end else begin
            a <= b;
            b <= a;
          end
        end
        cnt  <= '0;
        rem0 <= '0;
        rem1 <= '0;
      end
      RU_DIV: begin
        rem0 <= ge0 ? d0[RB-1:0] : t0[RB-1:0];
        rem1 <= ge1 ? d1[RB-1:0] : t1[RB-1:0];
        q0   <= {q0[RB-2:0], ge0};
        q1   <= {q1[RB-2:0], ge1};
        cnt  <= cnt + CW'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/hypotrochoid_point_generator.sv
// Top level of the hypotrochoid point generator: config, phase chain, CORDIC chain, output.
// Usage: a request on the input channel carries one step_index; each request gives exactly
// one point (x_pos, y_pos with FRAC_BITS fraction bits, is_final) on the output channel,
// in order. Both channels use valid and ready.
// Throughput: one request per cycle while in_ready is high. The stages form a single chain:
// a product stage, INDEX_BITS+RADIUS_BITS restoring cells for the modulo, 32 cells for the
// phase fraction, two angle preparation stages, CORDIC_STAGES micro-rotation cells per
// vector and a summing stage, then the output register.
// Radius writes restart the gcd sequencer, and in_ready stays low while it runs. Reset
// starts the same sequence for the reset radii, so no request is taken until it ends.
// When the receiver stalls, the output register holds its point; the chain still moves
// while its last stage is empty, then stops and in_ready drops.
// Configuration is written through cfg_write, cfg_index and cfg_data with no wait state.
`timescale 1ns / 1ps
`default_nettype none

module hypotrochoid_point_generator
  import hpg_pkg::*;
#(
  parameter int RADIUS_BITS   = RADIUS_BITS_DEF,
  parameter int INDEX_BITS    = INDEX_BITS_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                                           clk,
  input  wire logic                                           rst,
  input  wire logic                                           cfg_write,
  input  wire logic [CFG_IDX_BITS-1:0]                        cfg_index,
  input  wire logic [cfg_width(RADIUS_BITS, INDEX_BITS)-1:0]  cfg_data,
  input  wire logic                                           in_valid,
  output logic                                                in_ready,
  input  wire logic [INDEX_BITS-1:0]                          step_index,
  output logic                                                out_valid,
  input  wire logic                                           out_ready,
  output logic signed [OUT_BITS-1:0]                          x_pos,
  output logic signed [OUT_BITS-1:0]                          y_pos,
  output logic                                                is_final
);

  localparam int RB    = RADIUS_BITS;
  localparam int IB    = INDEX_BITS;
  localparam int PB    = IB + RB;
  localparam int CS    = CORDIC_STAGES;
  localparam int XW    = RB + 32;
  localparam int ZW    = 33;
  localparam int NPIPE = PB + CS + 36;

  localparam logic signed [XW-1:0] RND    = XW'(64'd1 << (29 - FRAC_BITS));
  localparam logic signed [XW-1:0] OUT_HI = XW'((64'd1 << (OUT_BITS - 1)) - 64'd1);
  localparam logic signed [XW-1:0] OUT_LO = -OUT_HI - XW'(1);

  // Configuration registers.
  logic [RB-1:0]       outer;
  logic [RB-1:0]       inner;
  logic [RB-1:0]       pen;
  logic [IB-1:0]       npts;
  logic [IB-1:0]       fin_idx;
  logic [ROT_BITS-1:0] rot;

  logic                ratio_start;
  logic [RB-1:0]       count;
  logic [RB-1:0]       adiff;
  ratio_status_t       rstat;

  always_ff @(posedge clk) begin
    if (rst) begin
      outer   <= RB'(RST_OUTER);
      inner   <= RB'(RST_INNER);
      pen     <= RB'(RST_PEN);
      npts    <= IB'(RST_POINTS);
      fin_idx <= IB'(RST_FINAL);
      rot     <= ROT_BITS'(RST_ROT);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_OUTER:  outer   <= cfg_data[RB-1:0];
        CFG_INNER:  inner   <= cfg_data[RB-1:0];
        CFG_PEN:    pen     <= cfg_data[RB-1:0];
        CFG_POINTS: npts    <= cfg_data[IB-1:0];
        CFG_FINAL:  fin_idx <= cfg_data[IB-1:0];
        CFG_ROT:    rot     <= cfg_data[ROT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign ratio_start = cfg_write && ((cfg_reg_t'(cfg_index) == CFG_OUTER) ||
                                     (cfg_reg_t'(cfg_index) == CFG_INNER));

  hpg_ratio_unit #(.RADIUS_BITS(RB)) u_ratio (
    .clk    (clk),
    .rst    (rst),
    .start  (ratio_start),
    .outer  (outer),
    .inner  (inner),
    .count  (count),
    .adiff  (adiff),
    .status (rstat)
  );

  // Derived configuration values.
  logic [IB-1:0] npts_eff;
  logic [RB-1:0] rr;
  logic          r_lt;
  logic [RB-1:0] big;

  always_comb begin
    npts_eff = (npts == '0) ? IB'(1) : npts;
    rr       = (inner == '0) ? RB'(1) : inner;
    r_lt     = (outer < rr);
    big      = r_lt ? (rr - outer) : (outer - rr);
  end

  // Flow control.
  logic             en_out;
  logic             en_front;
  logic             acc;
  logic [NPIPE-1:0] vld;
  logic [NPIPE-1:0] fin;

  always_comb begin
    en_out   = !out_valid || out_ready;
    en_front = en_out || !vld[NPIPE-1];
    in_ready = en_front && !rstat.busy;
    acc      = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en_front) begin
      vld <= {vld[NPIPE-2:0], acc};
    end
  end

  always_ff @(posedge clk) begin
    if (en_front) begin
      fin <= {fin[NPIPE-2:0], (step_index == fin_idx)};
    end
  end

  // Index products for both phases.
  logic [PB-1:0] prod_t;
  logic [PB-1:0] prod_p;

  always_ff @(posedge clk) begin
    if (en_front) begin
      prod_t <= {RB'(0), step_index} * {IB'(0), count};
      prod_p <= {RB'(0), step_index} * {IB'(0), adiff};
    end
  end

  // Lane 0 is the rolling phase, lane 1 the pen phase.
  logic [IB-1:0]         mrem [2][PB+1];
  logic [PB-1:0]         msw  [2][PB+1];
  logic [IB-1:0]         prem [2][PHASE_BITS+1];
  logic [PHASE_BITS-1:0] psw  [2][PHASE_BITS+1];

  assign mrem[0][0] = '0;
  assign mrem[1][0] = '0;
  assign msw[0][0]  = prod_t;
  assign msw[1][0]  = prod_p;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    assign prem[l][0] = mrem[l][PB];
    assign psw[l][0]  = '0;

    for (genvar k = 0; k < PB; k++) begin : g_mod
      hpg_div_cell #(.W(IB), .SW(PB)) u_cell (
        .clk     (clk),
        .en      (en_front),
        .d       (npts_eff),
        .rem_in  (mrem[l][k]),
        .sw_in   (msw[l][k]),
        .rem_out (mrem[l][k+1]),
        .sw_out  (msw[l][k+1])
      );
    end

    for (genvar k = 0; k < PHASE_BITS; k++) begin : g_frac
      hpg_div_cell #(.W(IB), .SW(PHASE_BITS)) u_cell (
        .clk     (clk),
        .en      (en_front),
        .d       (npts_eff),
        .rem_in  (prem[l][k]),
        .sw_in   (psw[l][k]),
        .rem_out (prem[l][k+1]),
        .sw_out  (psw[l][k+1])
      );
    end
  end

  // Angle preparation: rotation offset, quadrant fold and start vectors.
  logic [PHASE_BITS-1:0] rot32;
  logic [PHASE_BITS-1:0] ang    [2];
  logic [PHASE_BITS-1:0] folded [2];
  logic [PHASE_BITS-1:0] fold_t [2];
  logic [PHASE_BITS-1:0] mag_s  [2];
  logic                  flip   [2];
  logic [RB-1:0]         mag    [2];
  logic signed [XW-1:0]  x_mag  [2];

  logic                  p1_neg [2];
  logic [30:0]           p1_us  [2];
  logic signed [XW-1:0]  p1_x   [2];
  logic [61:0]           zprod  [2];

  logic signed [XW-1:0]  cx [2][CS+1];
  logic signed [XW-1:0]  cy [2][CS+1];
  logic signed [ZW-1:0]  cz [2][CS+1];

  always_comb begin
    rot32  = {rot, {(PHASE_BITS - ROT_BITS){1'b0}}};
    ang[0] = psw[0][PHASE_BITS] + rot32 + {r_lt, {(PHASE_BITS - 1){1'b0}}};
    ang[1] = rstat.neg ? (rot32 + psw[1][PHASE_BITS]) : (rot32 - psw[1][PHASE_BITS]);
    mag[0] = big;
    mag[1] = pen;
    for (int l = 0; l < 2; l++) begin
      fold_t[l] = ang[l] + 32'h4000_0000;
      flip[l]   = fold_t[l][31];
      folded[l] = flip[l] ? (ang[l] - 32'h8000_0000) : ang[l];
      mag_s[l]  = folded[l][31] ? (32'd0 - folded[l]) : folded[l];
      x_mag[l]  = $signed(XW'(mag[l]) * XW'(GAIN_FIX));
      zprod[l]  = {31'd0, p1_us[l]} * {31'd0, HALF_PI_FIX};
    end
  end

  always_ff @(posedge clk) begin
    if (en_front) begin
      for (int l = 0; l < 2; l++) begin
        p1_neg[l] <= folded[l][31];
        p1_us[l]  <= mag_s[l][30:0];
        p1_x[l]   <= flip[l] ? -x_mag[l] : x_mag[l];
        cx[l][0]  <= p1_x[l];
        cy[l][0]  <= '0;
        cz[l][0]  <= p1_neg[l] ? -$signed({1'b0, zprod[l][61:30]})
                               : $signed({1'b0, zprod[l][61:30]});
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_rot
    for (genvar k = 0; k < CS; k++) begin : g_stage
      hpg_cordic_cell #(.XW(XW), .ZW(ZW), .K(k)) u_cell (
        .clk   (clk),
        .en    (en_front),
        .x_in  (cx[l][k]),
        .y_in  (cy[l][k]),
        .z_in  (cz[l][k]),
        .x_out (cx[l][k+1]),
        .y_out (cy[l][k+1]),
        .z_out (cz[l][k+1])
      );
    end
  end

  // Sum of the two vectors, then rounding and saturation into the output register.
  logic signed [XW-1:0] sx;
  logic signed [XW-1:0] sy;
  logic signed [XW-1:0] rx;
  logic signed [XW-1:0] ry;

  always_ff @(posedge clk) begin
    if (en_front) begin
      sx <= cx[0][CS] + cx[1][CS];
      sy <= cy[0][CS] + cy[1][CS];
    end
  end

  function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [XW-1:0] v);
    logic signed [OUT_BITS-1:0] r;
    if (v > OUT_HI) begin
      r = OUT_HI[OUT_BITS-1:0];
    end else if (v < OUT_LO) begin
      r = OUT_LO[OUT_BITS-1:0];
    end else begin
      r = v[OUT_BITS-1:0];
    end
    return r;
  endfunction

  always_comb begin
    rx = (sx + RND) >>> (30 - FRAC_BITS);
    ry = (sy + RND) >>> (30 - FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= vld[NPIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      x_pos    <= sat_out(rx);
      y_pos    <= sat_out(ry);
      is_final <= fin[NPIPE-1];
    end
  end

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the hypotrochoid point generator with a predictor and random traffic.
`timescale 1ns / 1ps

module testbench;
  import hpg_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;
  localparam int DRAIN_CYCLES = 90;

  typedef struct {
    logic signed [OUT_BITS-1:0] x;
    logic signed [OUT_BITS-1:0] y;
    logic fin;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] step_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_BITS-1:0] x_pos;
  logic signed [OUT_BITS-1:0] y_pos;
  logic is_final;

  hypotrochoid_point_generator uut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .step_index(step_index), .out_valid(out_valid), .out_ready(out_ready),
    .x_pos(x_pos), .y_pos(y_pos), .is_final(is_final)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the configuration registers and the derived ratios.
  longint unsigned sh_outer, sh_inner, sh_pen, sh_points, sh_final, sh_rot;
  longint unsigned sh_turns;
  longint sh_diff;

  logic [15:0] pending_steps[$];
  point_t expected_points[$];
  int tx_idle_pct = 8;
  int rx_idle_pct = 73;
  int errors = 0;
  int points_seen = 0;
  int hold_cycles = 0;
  bit hold_done = 1'b0;

  longint atan_q30[16] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                           33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                           524287, 262143, 131071, 65535, 32767};

  function automatic void refresh_ratios();
    longint unsigned a, b, t, rr;
    a = sh_outer;
    b = (sh_inner != 0) ? sh_inner : 1;
    rr = b;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    sh_turns = rr / a;
    sh_diff = (longint'(sh_outer) - longint'(rr)) / longint'(a);
  endfunction

  function automatic longint unsigned turn_fraction(longint unsigned idx, longint unsigned mult,
                                                    longint unsigned n);
    longint unsigned m;
    m = (idx * mult) % n;
    return ((m << 32) / n) & 64'hFFFF_FFFF;
  endfunction

  // Rotates a vector of the given magnitude to a 32-bit turn angle, 30 fraction bits out.
  function automatic void cordic_rotate(longint unsigned mag, logic [31:0] angle,
                                        output longint ox, output longint oy);
    logic [31:0] a;
    longint x, y, s, z, dx, dy;
    longint unsigned us;
    a = angle;
    x = longint'(mag) * 652032874;
    y = 0;
    if (32'(a + 32'h4000_0000) >= 32'h8000_0000) begin
      a = a - 32'h8000_0000;
      x = -x;
    end
    s = longint'($signed(a));
    us = (s < 0) ? -s : s;
    z = longint'((us * 64'd1686629713) >> 30);
    if (s < 0) z = -z;
    for (int k = 0; k < 16; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q30[k];
      end else begin
        x += dx; y -= dy; z += atan_q30[k];
      end
    end
    ox = x;
    oy = y;
  endfunction

  function automatic logic signed [OUT_BITS-1:0] round_saturate(longint v);
    longint r;
    r = (v + (longint'(1) << 21)) >>> 22;
    if (r > 524287) r = 524287;
    if (r < -524288) r = -524288;
    return r[OUT_BITS-1:0];
  endfunction

  function automatic point_t predict_point(logic [15:0] step);
    longint unsigned idx, n, rr, adiff, rot, th, ph, big;
    logic [31:0] a1, a2;
    longint x1, y1, x2, y2;
    point_t p;
    idx = step;
    n = (sh_points != 0) ? sh_points : 1;
    rr = (sh_inner != 0) ? sh_inner : 1;
    adiff = (sh_diff < 0) ? -sh_diff : sh_diff;
    rot = (sh_rot << 16) & 64'hFFFF_FFFF;
    th = turn_fraction(idx, sh_turns, n);
    ph = turn_fraction(idx, adiff, n);
    big = (sh_outer >= rr) ? sh_outer - rr : rr - sh_outer;
    if (sh_diff < 0) ph = (64'h1_0000_0000 - ph) & 64'hFFFF_FFFF;
    a1 = 32'(th + rot);
    a2 = 32'(rot + 64'h1_0000_0000 - ph);
    if (sh_outer < rr) a1 = a1 + 32'h8000_0000;
    cordic_rotate(big, a1, x1, y1);
    cordic_rotate(sh_pen, a2, x2, y2);
    p.x = round_saturate(x1 + x2);
    p.y = round_saturate(y1 + y2);
    p.fin = (idx == sh_final);
    return p;
  endfunction

  // Driver: takes the next step index from the pending queue.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_points.push_back(predict_point(step_index));
      if (!in_valid || in_ready) begin
        if (pending_steps.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          step_index <= pending_steps.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, with one long hold to fill the pipeline.
  always @(posedge clk) begin
    point_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        points_seen++;
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected point x=%0d y=%0d final=%0b", $time, x_pos, y_pos,
                   is_final);
          errors++;
        end else begin
          want = expected_points.pop_front();
          if (x_pos !== want.x) begin
            $display("%0t: x_pos expected %0d actual %0d", $time, want.x, x_pos);
            errors++;
          end
          if (y_pos !== want.y) begin
            $display("%0t: y_pos expected %0d actual %0d", $time, want.y, y_pos);
            errors++;
          end
          if (is_final !== want.fin) begin
            $display("%0t: is_final expected %0b actual %0b", $time, want.fin, is_final);
            errors++;
          end
        end
        if (points_seen == 30 && !hold_done) begin
          hold_done <= 1'b1;
          hold_cycles <= 400;
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_OUTER:  sh_outer = val[9:0];
      CFG_INNER:  sh_inner = val[9:0];
      CFG_PEN:    sh_pen = val[9:0];
      CFG_POINTS: sh_points = val;
      CFG_FINAL:  sh_final = val;
      CFG_ROT:    sh_rot = val;
      default: ;
    endcase
    refresh_ratios();
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    while (pending_steps.size() > 0 || in_valid || expected_points.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random(input int count, input logic [15:0] near);
    logic [15:0] v;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: v = near;
        1: v = 16'($urandom_range(0, 2000));
        default: v = 16'($urandom);
      endcase
      pending_steps.push_back(v);
    end
  endtask

  initial begin
    sh_outer = RST_OUTER; sh_inner = RST_INNER; sh_pen = RST_PEN;
    sh_points = RST_POINTS; sh_final = RST_FINAL; sh_rot = RST_ROT;
    refresh_ratios();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset values first, with the index extremes and the final point.
    pending_steps = '{16'd0, 16'd65535, 16'd360, 16'd359, 16'd1, 16'd180, 16'd32768, 16'd90};
    queue_random(80, 16'd360);
    drain();

    // Zero radii, zero point count, upper data bits that must be ignored.
    write_reg(CFG_OUTER, 16'hFC00);
    write_reg(CFG_INNER, 16'hFC00);
    write_reg(CFG_PEN, 16'd1023);
    write_reg(CFG_POINTS, 16'd0);
    write_reg(CFG_FINAL, 16'd65535);
    write_reg(CFG_ROT, 16'd65535);
    pending_steps = '{16'd0, 16'd65535, 16'd7};
    queue_random(80, 16'd65535);
    drain();

    tx_idle_pct = 73;
    rx_idle_pct = 8;
    write_reg(CFG_OUTER, 16'd1023);
    write_reg(CFG_INNER, 16'd1);
    write_reg(CFG_PEN, 16'd0);
    write_reg(CFG_POINTS, 16'd65535);
    write_reg(CFG_FINAL, 16'd0);
    write_reg(CFG_ROT, 16'd16384);
    write_reg(CFG_SPARE_LO, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 16'h0000);
    pending_steps = '{16'd0, 16'd65535, 16'd65534};
    queue_random(80, 16'd0);
    drain();

    // Inner circle larger than the outer one gives a negative difference.
    write_reg(CFG_OUTER, 16'd30);
    write_reg(CFG_INNER, 16'd100);
    write_reg(CFG_PEN, 16'd55);
    write_reg(CFG_POINTS, 16'd7);
    write_reg(CFG_FINAL, 16'd6);
    write_reg(CFG_ROT, 16'd32768);
    queue_random(85, 16'd6);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int ph = 0; ph < 2; ph++) begin
      write_reg(CFG_OUTER, 16'($urandom));
      write_reg(CFG_INNER, 16'($urandom_range(1, 1023)));
      write_reg(CFG_PEN, 16'($urandom));
      write_reg(CFG_POINTS, 16'($urandom_range(1, 65535)));
      write_reg(CFG_FINAL, 16'($urandom_range(0, 300)));
      write_reg(CFG_ROT, 16'($urandom));
      queue_random(85, 16'(sh_final));
      drain();
    end

    $display("Checked %0d points over six register settings, including zero radii,", points_seen);
    $display("a zero point count, a negative difference and a long output stall.");
    if (errors == 0) begin
      $display("[hypotrochoid_point_generator] OK");
    end else begin
      $display("[hypotrochoid_point_generator] ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timed out with %0d points still expected.", expected_points.size());
    $display("[hypotrochoid_point_generator] ERROR");
    $finish;
  end

endmodule
